FILE: rtl/core/sacb_pkg.sv
// Shared types, constants and the channel blend function for the
// surface alpha / color key blend block. No dependencies.
`timescale 1ns / 1ps

package sacb_pkg;

    localparam int PIXEL_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int FRAC_BITS = 8;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    typedef enum logic [1:0] {
        DEPTH_8   = 2'd0,
        DEPTH_565 = 2'd1,
        DEPTH_24  = 2'd2,
        DEPTH_32  = 2'd3
    } t_depth;

    typedef enum logic [1:0] {
        REG_DEPTH_MODE    = 2'd0,
        REG_SURFACE_ALPHA = 2'd1,
        REG_KEY_COLOR     = 2'd2,
        REG_KEY_ENABLE    = 2'd3
    } t_reg_idx;

    localparam t_depth             RST_DEPTH_MODE = DEPTH_32;
    localparam logic [CHAN_W-1:0]  RST_ALPHA      = 8'hFF;
    localparam logic [PIXEL_W-1:0] RST_KEY_COLOR  = '0;
    localparam logic               RST_KEY_EN     = 1'b0;

    // d + floor(a * (s - d) / 256); the result always lies between d and s,
    // so the sum wraps back into range when taken modulo 2^CHAN_W.
    function automatic logic [CHAN_W-1:0] mix_chan(
        input logic [CHAN_W-1:0] s,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] a
    );
        logic signed [CHAN_W:0]       diff;
        logic signed [2*CHAN_W+1:0]   prod;
        diff = signed'({1'b0, s}) - signed'({1'b0, d});
        prod = diff * signed'({1'b0, a});
        return d + prod[FRAC_BITS +: CHAN_W];
    endfunction

endpackage

FILE: rtl/core/sacb_if.sv
// Valid/ready channel interfaces for pixel pairs in and blended pixels out.
// Depends on sacb_pkg.
`timescale 1ns / 1ps

interface sacb_in_if
    import sacb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] src_pix;
    logic [PIXEL_W-1:0] dst_pix;

    modport source (output valid, output src_pix, output dst_pix, input ready);
    modport sink   (input valid, input src_pix, input dst_pix, output ready);
endinterface

interface sacb_out_if
    import sacb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] out_pixel;
    logic               keyed_out;

    modport source (output valid, output out_pixel, output keyed_out, input ready);
    modport sink   (input valid, input out_pixel, input keyed_out, output ready);
endinterface

FILE: rtl/core/surface_alpha_colorkey_blend.sv
// Surface alpha / color key blend: top level with APB register file and
// two-stage pixel pipeline. Depends on sacb_pkg and sacb_if.
//
// One pixel pair (source, destination) per transaction goes in, one
// composited pixel comes out. A new transaction can be taken every cycle
// while ready is high: the pair lands in an input register, the blend
// (three 8x9 multipliers, one per color channel lane) sits between that
// register and the result register that drives o_pix.valid (two register
// stages from the input pins to the output), and throughput is one pixel
// per clock without consumer stalls. The result register keeps the
// input side moving while a finished pixel waits for the consumer; ready
// only drops when both stages are full and the consumer stalls. Each
// channel gets d + floor(alpha*(s-d)/256). Depth modes: 8-bit, RGB565
// (fields blended separately), 24-bit, and 32-bit with the top byte taken
// from the destination. Bits above the format are ignored on input and
// zero on output. With keying on, a source equal to the low bits of the
// key passes the masked destination through and flags keyed_out.
// Registers (APB, byte address 4*i): 0 depth_mode, 1 surface_alpha,
// 2 key_color, 3 key_enable. Write them only while the pipeline is empty.
`timescale 1ns / 1ps

module surface_alpha_colorkey_blend
    import sacb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // pixel channels
    sacb_in_if.sink            i_pix,
    sacb_out_if.source         o_pix
);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    t_depth             r_depth;
    logic [CHAN_W-1:0]  r_alpha;
    logic [PIXEL_W-1:0] r_key;
    logic               r_key_en;

    t_reg_idx w_reg_sel;
    logic     w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_sel = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= RST_DEPTH_MODE;
            r_alpha  <= RST_ALPHA;
            r_key    <= RST_KEY_COLOR;
            r_key_en <= RST_KEY_EN;
        end else if (w_cfg_wr) begin
            case (w_reg_sel)
                REG_DEPTH_MODE:    r_depth  <= t_depth'(pwdata[1:0]);
                REG_SURFACE_ALPHA: r_alpha  <= pwdata[CHAN_W-1:0];
                REG_KEY_COLOR:     r_key    <= pwdata[PIXEL_W-1:0];
                REG_KEY_ENABLE:    r_key_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back: plain mux on the register index
    always_comb begin
        prdata = '0;
        case (w_reg_sel)
            REG_DEPTH_MODE:    prdata = {{(PDATA_W-2){1'b0}}, r_depth};
            REG_SURFACE_ALPHA: prdata = {{(PDATA_W-CHAN_W){1'b0}}, r_alpha};
            REG_KEY_COLOR:     prdata = r_key;
            REG_KEY_ENABLE:    prdata = {{(PDATA_W-1){1'b0}}, r_key_en};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: stage 1 = input register, stage 2 = result register
    // ------------------------------------------------------------------
    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_src;
    logic [PIXEL_W-1:0] r_dst;
    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_out_pixel;
    logic               r_keyed;

    logic w_s2_ready;
    logic w_s1_ready;
    logic w_in_take;
    logic w_s1_adv;

    // Stage 2 frees up when empty or when the consumer takes its pixel
    assign w_s2_ready = !r_out_valid || o_pix.ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign w_in_take  = i_pix.valid && w_s1_ready;
    assign w_s1_adv   = r_s1_valid && w_s2_ready;

    assign i_pix.ready = w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    // Hold the pair until stage 2 takes it
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_src <= i_pix.src_pix;
            r_dst <= i_pix.dst_pix;
        end
    end

    // ------------------------------------------------------------------
    // Blend datapath (between stage 1 and stage 2)
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] w_mask;
    logic [PIXEL_W-1:0] w_src_m;
    logic [PIXEL_W-1:0] w_dst_m;
    logic               w_key_hit;
    logic [CHAN_W-1:0]  w_s_ln [3];
    logic [CHAN_W-1:0]  w_d_ln [3];
    logic [CHAN_W-1:0]  w_mix  [3];
    logic [PIXEL_W-1:0] w_blend;
    logic [PIXEL_W-1:0] n_out_pixel;
    logic               n_keyed;

    always_comb begin
        case (r_depth)
            DEPTH_8:   w_mask = 32'h0000_00FF;
            DEPTH_565: w_mask = 32'h0000_FFFF;
            DEPTH_24:  w_mask = 32'h00FF_FFFF;
            default:   w_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign w_src_m   = r_src & w_mask;
    assign w_dst_m   = r_dst & w_mask;
    assign w_key_hit = r_key_en && (w_src_m == (r_key & w_mask));

    // Steer fields onto three 8-bit lanes; narrow fields are zero-extended
    always_comb begin
        case (r_depth)
            DEPTH_8: begin
                w_s_ln[0] = w_src_m[7:0];
                w_d_ln[0] = w_dst_m[7:0];
                w_s_ln[1] = '0;
                w_d_ln[1] = '0;
                w_s_ln[2] = '0;
                w_d_ln[2] = '0;
            end
            DEPTH_565: begin
                w_s_ln[0] = {3'b000, w_src_m[4:0]};
                w_d_ln[0] = {3'b000, w_dst_m[4:0]};
                w_s_ln[1] = {2'b00, w_src_m[10:5]};
                w_d_ln[1] = {2'b00, w_dst_m[10:5]};
                w_s_ln[2] = {3'b000, w_src_m[15:11]};
                w_d_ln[2] = {3'b000, w_dst_m[15:11]};
            end
            default: begin
                w_s_ln[0] = w_src_m[7:0];
                w_d_ln[0] = w_dst_m[7:0];
                w_s_ln[1] = w_src_m[15:8];
                w_d_ln[1] = w_dst_m[15:8];
                w_s_ln[2] = w_src_m[23:16];
                w_d_ln[2] = w_dst_m[23:16];
            end
        endcase
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign w_mix[g] = mix_chan(w_s_ln[g], w_d_ln[g], r_alpha);
    end

    always_comb begin
        case (r_depth)
            DEPTH_8:   w_blend = {24'h0, w_mix[0]};
            DEPTH_565: w_blend = {16'h0, w_mix[2][4:0], w_mix[1][5:0], w_mix[0][4:0]};
            DEPTH_24:  w_blend = {8'h0, w_mix[2], w_mix[1], w_mix[0]};
            default:   w_blend = {w_dst_m[31:24], w_mix[2], w_mix[1], w_mix[0]};
        endcase
    end

    // Keyed pixel: pass the masked destination through
    assign n_out_pixel = w_key_hit ? w_dst_m : w_blend;
    assign n_keyed     = w_key_hit;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_pixel <= n_out_pixel;
            r_keyed     <= n_keyed;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_pixel = r_out_pixel;
    assign o_pix.keyed_out = r_keyed;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A new pair is never taken over a stage-1 pair that cannot move on
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |-> (!r_s1_valid || w_s2_ready))
        else $error("stage 1 overwritten while stalled");

    // A stage-1 pair that advances shows up at the output next cycle
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid)
        else $error("advanced pixel lost before result register");

    // An untaken result is never dropped
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pix.ready) |=> r_out_valid)
        else $error("result dropped while consumer stalled");

    // Input side stays open whenever the result register is free
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_pix.ready)
        else $error("input stalled with free result register");

endmodule

FILE: test/surface_alpha_colorkey_blend_test.sv
// Self-checking bench for surface_alpha_colorkey_blend: directed corner pixels,
// then randomized pixel streams under several register settings and idling mixes.
// Depends on sacb_pkg, sacb_in_if / sacb_out_if and the block itself.
`timescale 1ns / 1ps

module surface_alpha_colorkey_blend_test;
    import sacb_pkg::*;

    // Cycles without any accepted transaction or register write before giving up.
    localparam int STALL_LIMIT  = 2000;
    // Cycles to let the two-stage pipeline settle after the last result.
    localparam int SETTLE_TICKS = 6;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_PAIRS  = 112;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [PIXEL_W-1:0] src;
        logic [PIXEL_W-1:0] dst;
    } t_pixel_pair;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               keyed;
    } t_blend_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sacb_in_if  pix_in ();
    sacb_out_if pix_out ();

    // Pixel pairs waiting to be offered, and blended pixels still owed by the block.
    t_pixel_pair   pending_pairs[$];
    t_blend_result owed_blends[$];

    // Shadow of the register file, updated at the write edge.
    t_depth             cfg_depth;
    logic [CHAN_W-1:0]  cfg_alpha;
    logic [PIXEL_W-1:0] cfg_key;
    logic               cfg_key_en;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int quiet_cycles;
    bit reg_write_edge;

    surface_alpha_colorkey_blend dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [PIXEL_W-1:0] format_mask(t_depth depth);
        case (depth)
            DEPTH_8:   return 32'h0000_00FF;
            DEPTH_565: return 32'h0000_FFFF;
            DEPTH_24:  return 32'h00FF_FFFF;
            default:   return 32'hFFFF_FFFF;
        endcase
    endfunction

    // One lane: d + floor(alpha * (s - d) / 256). Going downward, round the
    // magnitude up so the floor holds for a negative difference.
    function automatic logic [CHAN_W-1:0] blend_lane(
        logic [CHAN_W-1:0] s,
        logic [CHAN_W-1:0] d,
        logic [CHAN_W-1:0] alpha
    );
        logic [2*CHAN_W-1:0] scaled;
        if (s >= d) begin
            scaled = 16'(alpha) * 16'(s - d);
            return d + CHAN_W'(scaled >> FRAC_BITS);
        end
        scaled = 16'(alpha) * 16'(d - s) + 16'((1 << FRAC_BITS) - 1);
        return d - CHAN_W'(scaled >> FRAC_BITS);
    endfunction

    // Blend the field of the given width starting at bit lsb, in place.
    function automatic logic [PIXEL_W-1:0] blend_field(
        logic [PIXEL_W-1:0] s,
        logic [PIXEL_W-1:0] d,
        int                 lsb,
        int                 width
    );
        logic [CHAN_W-1:0] field_mask;
        field_mask = CHAN_W'((1 << width) - 1);
        return PIXEL_W'(blend_lane(CHAN_W'(s >> lsb) & field_mask,
                                   CHAN_W'(d >> lsb) & field_mask, cfg_alpha)) << lsb;
    endfunction

    function automatic t_blend_result predict_blend(logic [PIXEL_W-1:0] src,
                                                    logic [PIXEL_W-1:0] dst);
        logic [PIXEL_W-1:0] fmt;
        logic [PIXEL_W-1:0] s;
        logic [PIXEL_W-1:0] d;
        logic [PIXEL_W-1:0] mixed;
        t_blend_result      res;
        fmt = format_mask(cfg_depth);
        s   = src & fmt;
        d   = dst & fmt;
        // Keyed source: pass the masked destination straight through.
        if (cfg_key_en && s == (cfg_key & fmt)) begin
            res.pixel = d;
            res.keyed = 1'b1;
            return res;
        end
        case (cfg_depth)
            DEPTH_8:   mixed = blend_field(s, d, 0, 8);
            DEPTH_565: mixed = blend_field(s, d, 11, 5) | blend_field(s, d, 5, 6)
                             | blend_field(s, d, 0, 5);
            DEPTH_24:  mixed = blend_field(s, d, 16, 8) | blend_field(s, d, 8, 8)
                             | blend_field(s, d, 0, 8);
            default:   mixed = (d & 32'hFF00_0000) | blend_field(s, d, 16, 8)
                             | blend_field(s, d, 8, 8) | blend_field(s, d, 0, 8);
        endcase
        res.pixel = mixed & fmt;
        res.keyed = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer pending pairs, predict on every accepted transaction
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                owed_blends.push_back(predict_blend(pix_in.src_pix, pix_in.dst_pix));
            end
            // Advance only when the current transaction is gone or none is held.
            if (!pix_in.valid || pix_in.ready) begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_pixel_pair next_pair;
                    next_pair = pending_pairs.pop_front();
                    pix_in.src_pix <= next_pair.src;
                    pix_in.dst_pix <= next_pair.dst;
                    pix_in.valid   <= 1'b1;
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, compare each result with the oldest owed one
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                if (owed_blends.size() == 0) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("unexpected result: out_pixel %h keyed_out %b",
                                 pix_out.out_pixel, pix_out.keyed_out);
                    end
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    t_blend_result want;
                    want = owed_blends.pop_front();
                    if (pix_out.out_pixel !== want.pixel || pix_out.keyed_out !== want.keyed) begin
                        if (mismatch_count < REPORT_MAX) begin
                            $display("out_pixel expected %h got %h, keyed_out expected %b got %b",
                                     want.pixel, pix_out.out_pixel,
                                     want.keyed, pix_out.keyed_out);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
                || reg_write_edge || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("surface_alpha_colorkey_blend: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Register access and phase helpers
    // ------------------------------------------------------------------

    // Setup cycle, then access cycle; the register takes the value at the edge
    // where the access is sampled with pready high.
    task automatic reg_write(t_reg_idx idx, logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        reg_write_edge = 1'b1;
        case (idx)
            REG_DEPTH_MODE:    cfg_depth  = t_depth'(value[1:0]);
            REG_SURFACE_ALPHA: cfg_alpha  = value[CHAN_W-1:0];
            REG_KEY_COLOR:     cfg_key    = value;
            default:           cfg_key_en = value[0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        reg_write_edge = 1'b0;
    endtask

    task automatic set_blend(t_depth depth, logic [CHAN_W-1:0] alpha,
                             logic [PIXEL_W-1:0] key, logic key_en);
        reg_write(REG_DEPTH_MODE, PDATA_W'(depth));
        reg_write(REG_SURFACE_ALPHA, PDATA_W'(alpha));
        reg_write(REG_KEY_COLOR, key);
        reg_write(REG_KEY_ENABLE, PDATA_W'(key_en));
    endtask

    task automatic queue_pair(logic [PIXEL_W-1:0] src, logic [PIXEL_W-1:0] dst);
        t_pixel_pair pair;
        pair.src = src;
        pair.dst = dst;
        pending_pairs.push_back(pair);
    endtask

    // Hold until every queued pair went in and every blend came back.
    task automatic drain;
        while (pending_pairs.size() != 0 || pix_in.valid || owed_blends.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    function automatic logic [PIXEL_W-1:0] saturated_pixel();
        logic [PIXEL_W-1:0] pix;
        for (int b = 0; b < 4; b++) begin
            pix[8*b +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return pix;
    endfunction

    // Random pairs biased toward key hits, near misses and saturated channels.
    task automatic queue_random_pairs(int count);
        logic [PIXEL_W-1:0] fmt;
        logic [PIXEL_W-1:0] src;
        logic [PIXEL_W-1:0] dst;
        int                 pick;
        fmt = format_mask(cfg_depth);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            src  = $urandom;
            dst  = $urandom;
            if (pick < 25) begin
                // exact key hit, random garbage above the format
                src = (cfg_key & fmt) | (src & ~fmt);
            end else if (pick < 35) begin
                // flip bits in one byte of the key
                src = cfg_key ^ (PIXEL_W'($urandom_range(1, 255)) << (8 * $urandom_range(3)));
            end else if (pick < 50) begin
                src = saturated_pixel();
                dst = saturated_pixel();
            end
            queue_pair(src, dst);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------

    initial begin
        logic [CHAN_W-1:0]  alpha;
        logic [PIXEL_W-1:0] key;
        int                 pick;

        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pix_in.valid      = 1'b0;
        pix_in.src_pix    = '0;
        pix_in.dst_pix    = '0;
        pix_out.ready     = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        mismatch_count    = 0;
        quiet_cycles      = 0;
        reg_write_edge    = 1'b0;
        cfg_depth         = RST_DEPTH_MODE;
        cfg_alpha         = RST_ALPHA;
        cfg_key           = RST_KEY_COLOR;
        cfg_key_en        = RST_KEY_EN;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 32-bit, full alpha, key zero but keying off.
        queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
        queue_pair(32'h1234_5678, 32'h9ABC_DEF0);
        drain();

        // Zero alpha keeps the destination everywhere.
        reg_write(REG_SURFACE_ALPHA, PDATA_W'(8'h00));
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // 8-bit: bits above the byte are ignored on input, zero on output.
        set_blend(DEPTH_8, 8'h80, 32'hFFFF_FFFF, 1'b0);
        queue_pair(32'hFFFF_FF00, 32'h0000_00FF);
        queue_pair(32'h0000_00FF, 32'hFFFF_FF00);
        drain();

        // RGB565 with keying on: fields blended apart, low half of the key used.
        set_blend(DEPTH_565, 8'h80, 32'hABCD_F81F, 1'b1);
        queue_pair(32'h0000_FFFF, 32'h0000_0000);
        queue_pair(32'hFFFF_0000, 32'h0000_FFFF);
        queue_pair(32'h1234_F81F, 32'hFFFF_ABCD);
        queue_pair(32'h0000_F81E, 32'h0000_1234);
        drain();

        // 24-bit: only a full three-byte match is a key hit.
        set_blend(DEPTH_24, 8'hC0, 32'h0012_3456, 1'b1);
        queue_pair(32'hAB12_3456, 32'hCDFF_EEDD);
        queue_pair(32'h0012_3457, 32'h00FF_EEDD);
        queue_pair(32'h0000_3456, 32'h0001_0203);
        queue_pair(32'h0012_0056, 32'hFFFF_FFFF);
        drain();

        // 32-bit: the top byte is part of the key compare.
        set_blend(DEPTH_32, 8'hFF, 32'h80FF_FFFF, 1'b1);
        queue_pair(32'h80FF_FFFF, 32'h1122_3344);
        queue_pair(32'h00FF_FFFF, 32'h1122_3344);
        drain();

        // 8-bit with an all-ones key: only the low byte is compared.
        set_blend(DEPTH_8, 8'h01, 32'hFFFF_FFFF, 1'b1);
        queue_pair(32'h1234_56FF, 32'h0000_0080);
        queue_pair(32'h0000_00FE, 32'h0000_0000);
        drain();

        // Random phases: fresh settings each time, idling mix rotating.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick = $urandom_range(3);
            alpha = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : CHAN_W'($urandom);
            pick = $urandom_range(3);
            key = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : PIXEL_W'($urandom);
            set_blend(t_depth'($urandom_range(3)), alpha, key, (ph % 3) != 0);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            queue_random_pairs(PHASE_PAIRS);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("surface_alpha_colorkey_blend: match");
        end else begin
            $display("surface_alpha_colorkey_blend: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sacb_pkg.sv
rtl/core/sacb_if.sv
rtl/core/surface_alpha_colorkey_blend.sv
test/surface_alpha_colorkey_blend_test.sv
